>>> rtl/core/kte_pkg.sv
package kte_pkg;

   // Line and multi-tap geometry.
   localparam int LINE_CHARS   = 32;
   localparam int TAPS_PER_KEY = 3;
   localparam int LEN_W        = $clog2(LINE_CHARS + 1);
   localparam int KEYS         = 9;

   // Key combinations with a special meaning.
   localparam logic [8:0] MASK_CLEAR = 9'h0C0;
   localparam logic [8:0] MASK_MODE  = 9'h018;
   localparam logic [8:0] MASK_SPACE = 9'h003;

   localparam logic [6:0]  CHAR_SPACE = 7'h20;
   localparam logic [6:0]  CHAR_ONE   = 7'h31;
   localparam logic [13:0] COUNT_MAX  = 14'd9999;

   localparam logic MODE_LETTER = 1'b0;
   localparam logic MODE_DIGIT  = 1'b1;

   // Multi-tap letters, one row per key, key 1 first.
   localparam logic [6:0] LETTER_TABLE [0:8][0:2] = '{
      '{7'h2E, 7'h51, 7'h5A},
      '{7'h41, 7'h42, 7'h43},
      '{7'h44, 7'h45, 7'h46},
      '{7'h47, 7'h48, 7'h49},
      '{7'h4A, 7'h4B, 7'h4C},
      '{7'h4D, 7'h4E, 7'h4F},
      '{7'h50, 7'h52, 7'h53},
      '{7'h54, 7'h55, 7'h56},
      '{7'h57, 7'h58, 7'h59}
   };

   typedef struct packed {
      logic       restart;
      logic [8:0] switches;
   } kte_req_type;

   typedef struct packed {
      logic        refresh;
      logic        shift_left;
      logic        write_enable;
      logic [6:0]  write_char;
      logic [4:0]  write_position;
      logic        clear_text;
      logic        digit_mode;
      logic        mode_changed;
      logic [13:0] press_count;
   } kte_rsp_type;

   typedef struct packed {
      logic [8:0]       last_switches;
      logic [1:0]       tap_index;
      logic [13:0]      handled_presses;
      logic [LEN_W-1:0] text_length;
      logic             entry_mode;
   } kte_state_type;

endpackage

>>> rtl/core/kte_step.sv
module kte_step (
   input  kte_pkg::kte_req_type   req_i,
   input  kte_pkg::kte_state_type state_i,
   output kte_pkg::kte_state_type state_o,
   output kte_pkg::kte_rsp_type   rsp_o
);
   import kte_pkg::*;

   // One key event: decode the mask, update the line state, form the result word.
   always_comb begin
      kte_state_type    st;
      logic             one_key;
      logic [3:0]       key;
      logic             full;
      logic [LEN_W-1:0] len_room;
      logic [1:0]       col;
      logic             counted;

      st = req_i.restart ? '0 : state_i;
      rsp_o = '0;
      rsp_o.refresh = req_i.restart;
      rsp_o.clear_text = req_i.restart;
      rsp_o.mode_changed = req_i.restart;
      counted = 1'b0;

      one_key = (req_i.switches != 9'd0) &&
                ((req_i.switches & (req_i.switches - 9'd1)) == 9'd0);
      key = 4'd0;
      for (int i = 0; i < KEYS; i++) begin
         if (req_i.switches[i]) begin
            key = 4'(KEYS - 1 - i);
         end
      end

      // A full line drops its first character before a new one is appended.
      full = st.text_length >= LEN_W'(LINE_CHARS);
      len_room = full ? LEN_W'(LINE_CHARS - 1) : st.text_length;
      col = (st.tap_index > 2'd2) ? 2'd2 : st.tap_index;

      if (one_key) begin
         counted = 1'b1;
         rsp_o.write_enable = 1'b1;
         if (st.entry_mode == MODE_LETTER) begin
            if (st.last_switches == req_i.switches) begin
               // Repeat tap rewrites the last cell with the next letter.
               rsp_o.write_char = LETTER_TABLE[key][col];
               rsp_o.write_position = (st.text_length == '0) ? 5'd0 :
                                      5'(st.text_length - LEN_W'(1));
               st.tap_index = (st.tap_index == 2'(TAPS_PER_KEY - 1)) ? 2'd0 :
                              st.tap_index + 2'd1;
            end else begin
               rsp_o.shift_left = full;
               rsp_o.write_char = LETTER_TABLE[key][0];
               rsp_o.write_position = 5'(len_room);
               st.tap_index = 2'(1 % TAPS_PER_KEY);
               st.text_length = len_room + LEN_W'(1);
            end
         end else begin
            rsp_o.shift_left = full;
            rsp_o.write_char = CHAR_ONE + 7'(key);
            rsp_o.write_position = 5'(len_room);
            st.text_length = len_room + LEN_W'(1);
         end
      end else if (req_i.switches == MASK_CLEAR) begin
         counted = 1'b1;
         rsp_o.clear_text = 1'b1;
         st.text_length = '0;
         st.tap_index = 2'd0;
      end else if (req_i.switches == MASK_MODE) begin
         counted = 1'b1;
         st.entry_mode = ~st.entry_mode;
         rsp_o.mode_changed = 1'b1;
         st.tap_index = 2'd0;
      end else if (req_i.switches == MASK_SPACE) begin
         counted = 1'b1;
         rsp_o.shift_left = full;
         rsp_o.write_enable = 1'b1;
         rsp_o.write_char = CHAR_SPACE;
         rsp_o.write_position = 5'(len_room);
         st.text_length = len_room + LEN_W'(1);
      end

      // Press counter wraps at the four-digit display limit.
      if (counted) begin
         st.handled_presses = (st.handled_presses == COUNT_MAX) ? 14'd0 :
                              st.handled_presses + 14'd1;
      end

      if (req_i.switches != 9'd0) begin
         rsp_o.refresh = 1'b1;
         st.last_switches = req_i.switches;
      end

      rsp_o.digit_mode = st.entry_mode;
      rsp_o.press_count = st.handled_presses;
      state_o = st;
   end

endmodule

>>> rtl/core/multi_tap_keypad_text_entry_top.sv
// Channel  Ports                          Direction  Contents
// req      req_valid/req_ready/req_word   in         restart flag, 9-key switch mask
// rsp      rsp_valid/rsp_ready/rsp_word   out        display commands, mode, press count
//
// Each request word produces exactly one response word, registered in the result register.
// One word is accepted per cycle while req_ready is high; the input register and the result register
// form a two-stage pipeline, and the line state updates as a word leaves the input stage.
// A stalled response holds the input stage; req_ready drops only when both stages are full.
// Synchronous active-high reset empties both stages and returns the line to letter mode.
module multi_tap_keypad_text_entry_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kte_pkg::kte_req_type  req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kte_pkg::kte_rsp_type  rsp_word
);
   import kte_pkg::*;

   kte_req_type   in_ff;
   logic          in_valid_ff;
   kte_rsp_type   rsp_ff;
   kte_rsp_type   rsp_in;
   logic          rsp_valid_ff;
   kte_state_type state_ff;
   kte_state_type state_in;
   logic          advance;

   // The input stage moves on whenever the result register is free or draining.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   kte_step u_step (
      .req_i   (in_ff),
      .state_i (state_ff),
      .state_o (state_in),
      .rsp_o   (rsp_in)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_ff <= req_word;
      end
   end

   // Line state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // The line never holds more characters than it has cells.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.text_length <= LEN_W'(LINE_CHARS))
      else $error("text length beyond line size");

   // The tap index stays inside the letter table row.
   a_tap_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.tap_index < 2'(TAPS_PER_KEY) || TAPS_PER_KEY == 4)
      else $error("tap index out of range");

   // The press counter stays within four decimal digits.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.handled_presses <= COUNT_MAX)
      else $error("press count out of range");

   // A restart word always yields a clear and a mode redraw.
   a_restart_clear: assert property (@(posedge clock) disable iff (reset)
      advance && in_ff.restart |=> rsp_valid_ff && rsp_ff.clear_text && rsp_ff.mode_changed)
      else $error("restart did not clear the display");

endmodule

>>> tb/sv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import kte_pkg::*;

   localparam int PRESS_MODULUS = 10000;
   localparam int RUN_LIMIT_NS  = 5_000_000;
   localparam int TAIL_CYCLES   = 8;
   localparam int MAX_PRINTED   = 100;

   // Multi-tap letters per key, key 1 first.
   localparam logic [7:0] TAP_LETTERS [0:8][0:2] = '{
      '{".", "Q", "Z"}, '{"A", "B", "C"}, '{"D", "E", "F"},
      '{"G", "H", "I"}, '{"J", "K", "L"}, '{"M", "N", "O"},
      '{"P", "R", "S"}, '{"T", "U", "V"}, '{"W", "X", "Y"}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   kte_req_type req_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   kte_rsp_type rsp_word;

   multi_tap_keypad_text_entry_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // Pending key words and the display commands they are expected to produce.
   kte_req_type keypad_words [$];
   kte_rsp_type display_cmds [$];
   kte_rsp_type oldest_cmd;

   int send_idle_pct = 30;
   int recv_idle_pct = 63;
   int error_count = 0;
   int words_accepted = 0;
   int cmds_checked = 0;
   int shifts_seen = 0;
   int wraps_seen = 0;
   int restarts_seen = 0;

   // Shadow copy of the line state.
   logic [8:0]        prev_switches;
   logic [1:0]        tap_pos;
   logic [13:0]       press_total;
   logic [LEN_W-1:0]  line_len;
   logic              entry_digits;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("%0t ns: mismatch: %s", $time, what);
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("response %0d field %s got %0d expected %0d",
                                   cmds_checked, name, got, want));
   endtask

   // A full line drops one character off the left before the next write.
   function automatic logic make_room();
      if (line_len >= LINE_CHARS) begin
         line_len = LEN_W'(LINE_CHARS - 1);
         shifts_seen++;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Works out the display command for one key word and advances the line state.
   function automatic kte_rsp_type predict_display(input kte_req_type w);
      kte_rsp_type      r;
      logic             counted;
      int               key;
      int               b;
      int               col;
      logic [LEN_W-1:0] pos;
      r = '0;
      counted = 1'b0;
      key = 0;
      if (w.restart) begin
         prev_switches = '0;
         tap_pos = '0;
         press_total = '0;
         line_len = '0;
         entry_digits = MODE_LETTER;
         r.refresh = 1'b1;
         r.clear_text = 1'b1;
         r.mode_changed = 1'b1;
         restarts_seen++;
      end
      if ($onehot(w.switches)) begin
         for (b = 0; b <= 8; b++)
            if (w.switches[b]) key = 8 - b;
         if (entry_digits == MODE_LETTER) begin
            if (prev_switches == w.switches) begin
               // Repeat tap replaces the last character with the next letter.
               col = (tap_pos > 2) ? 2 : int'(tap_pos);
               pos = (line_len == 0) ? '0 : line_len - 1'b1;
               r.write_enable = 1'b1;
               r.write_char = TAP_LETTERS[key][col][6:0];
               r.write_position = pos[4:0];
               tap_pos = 2'((int'(tap_pos) + 1) % TAPS_PER_KEY);
            end else begin
               r.shift_left = make_room();
               r.write_enable = 1'b1;
               r.write_char = TAP_LETTERS[key][0][6:0];
               r.write_position = line_len[4:0];
               tap_pos = 2'(1 % TAPS_PER_KEY);
               line_len = line_len + 1'b1;
            end
         end else begin
            r.shift_left = make_room();
            r.write_enable = 1'b1;
            r.write_char = 7'("1" + key);
            r.write_position = line_len[4:0];
            line_len = line_len + 1'b1;
         end
         counted = 1'b1;
      end else if (w.switches == MASK_CLEAR) begin
         r.clear_text = 1'b1;
         line_len = '0;
         tap_pos = '0;
         counted = 1'b1;
      end else if (w.switches == MASK_MODE) begin
         entry_digits = ~entry_digits;
         r.mode_changed = 1'b1;
         tap_pos = '0;
         counted = 1'b1;
      end else if (w.switches == MASK_SPACE) begin
         r.shift_left = make_room();
         r.write_enable = 1'b1;
         r.write_char = 7'(" ");
         r.write_position = line_len[4:0];
         line_len = line_len + 1'b1;
         counted = 1'b1;
      end
      if (counted) begin
         if (press_total == 14'(PRESS_MODULUS - 1)) begin
            press_total = '0;
            wraps_seen++;
         end else begin
            press_total = press_total + 1'b1;
         end
      end
      if (w.switches != '0) begin
         r.refresh = 1'b1;
         prev_switches = w.switches;
      end
      r.digit_mode = entry_digits;
      r.press_count = press_total;
      return r;
   endfunction

   task automatic queue_word(input logic restart, input logic [8:0] switches);
      kte_req_type w;
      w.restart = restart;
      w.switches = switches;
      keypad_words.push_back(w);
   endtask

   // Mostly multi-tap bursts and the special combinations, with some noise.
   task automatic queue_typing(input int count);
      int done;
      int pick;
      int reps;
      logic [8:0] key_mask;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 2) begin
            queue_word(1'b1, ($urandom_range(0, 1) != 0) ? 9'($urandom_range(0, 511)) : '0);
            done++;
         end else if (pick < 52) begin
            key_mask = 9'h100 >> $urandom_range(0, 8);
            reps = $urandom_range(1, 5);
            repeat (reps) queue_word(1'b0, key_mask);
            done += reps;
         end else if (pick < 55) begin
            queue_word(1'b0, MASK_CLEAR);
            done++;
         end else if (pick < 62) begin
            queue_word(1'b0, MASK_MODE);
            done++;
         end else if (pick < 74) begin
            queue_word(1'b0, MASK_SPACE);
            done++;
         end else if (pick < 80) begin
            queue_word(1'b0, '0);
         end else begin
            queue_word(1'b0, 9'($urandom_range(0, 511)));
            done++;
         end
      end
   endtask

   task automatic wait_drained();
      while (keypad_words.size() != 0)
         @(posedge clock);
   endtask

   // Driver: predicts each accepted word and presents the next pending one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_word <= '0;
      end else begin
         if (req_valid && req_ready) begin
            display_cmds.push_back(predict_display(req_word));
            words_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (keypad_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_word <= keypad_words.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each accepted response word with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (display_cmds.size() == 0) begin
               report_mismatch("response word with nothing expected");
            end else begin
               oldest_cmd = display_cmds.pop_front();
               check_field("refresh", rsp_word.refresh, oldest_cmd.refresh);
               check_field("shift_left", rsp_word.shift_left, oldest_cmd.shift_left);
               check_field("write_enable", rsp_word.write_enable, oldest_cmd.write_enable);
               check_field("write_char", rsp_word.write_char, oldest_cmd.write_char);
               check_field("write_position", rsp_word.write_position,
                           oldest_cmd.write_position);
               check_field("clear_text", rsp_word.clear_text, oldest_cmd.clear_text);
               check_field("digit_mode", rsp_word.digit_mode, oldest_cmd.digit_mode);
               check_field("mode_changed", rsp_word.mode_changed, oldest_cmd.mode_changed);
               check_field("press_count", rsp_word.press_count, oldest_cmd.press_count);
               cmds_checked++;
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Stimulus and end of run.
   initial begin
      prev_switches = '0;
      tap_pos = '0;
      press_total = '0;
      line_len = '0;
      entry_digits = MODE_LETTER;

      // Directed words: no key, multi-tap cycling, digits, combinations, restarts.
      queue_word(1'b0, '0);
      queue_word(1'b0, 9'h100);
      queue_word(1'b0, 9'h100);
      queue_word(1'b0, 9'h100);
      queue_word(1'b0, 9'h100);
      queue_word(1'b0, 9'h001);
      queue_word(1'b0, MASK_SPACE);
      queue_word(1'b0, 9'h1FF);
      queue_word(1'b0, 9'h001);
      queue_word(1'b0, MASK_MODE);
      queue_word(1'b0, 9'h100);
      queue_word(1'b0, 9'h001);
      queue_word(1'b0, 9'h001);
      queue_word(1'b0, MASK_MODE);
      queue_word(1'b0, 9'h010);
      queue_word(1'b0, MASK_CLEAR);
      queue_word(1'b1, '0);
      queue_word(1'b1, 9'h010);
      queue_word(1'b0, 9'h010);
      queue_word(1'b1, MASK_MODE);
      queue_word(1'b0, 9'h0AA);
      queue_word(1'b0, 9'h155);
      queue_word(1'b0, MASK_MODE);
      queue_typing(400);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      wait_drained();
      send_idle_pct <= 63;
      recv_idle_pct <= 30;
      queue_typing(400);

      wait_drained();
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      queue_typing(400);

      wait_drained();
      while (req_valid)
         @(posedge clock);
      while (display_cmds.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Summary: %0d key words accepted over three idling phases, %0d responses compared.",
               words_accepted, cmds_checked);
      $display("Summary: %0d line shifts, %0d press-count wraps and %0d restarts were exercised.",
               shifts_seen, wraps_seen, restarts_seen);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(RUN_LIMIT_NS);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> files.f
rtl/core/kte_pkg.sv
rtl/core/kte_step.sv
rtl/core/multi_tap_keypad_text_entry_top.sv
tb/sv/testbench.sv
